### hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the hall commutation core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge outside reset
`define HSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising clk edge, reset included
`define HSC_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hsc_pkg.sv
// ============================================================================
// hsc_pkg
// Types, constants and the sector table of the hall commutation core.
// ============================================================================
package hsc_pkg;

    // Field widths
    localparam int ADC_BITS   = 12;
    localparam int TALLY_BITS = 6;
    localparam int OVS_BITS   = 6;
    localparam int DUTY_BITS  = 8;
    localparam int HALL_BITS  = 3;
    localparam int VOTE_W     = (TALLY_BITS > OVS_BITS - 1) ? TALLY_BITS : OVS_BITS - 1;
    localparam int PROD_W     = ADC_BITS + DUTY_BITS;
    localparam int DIV_STEPS  = DUTY_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Stream widths
    localparam int S_TDATA_W  = ((HALL_BITS + ADC_BITS + 7) / 8) * 8;
    localparam int M_USED_W   = 6 * DUTY_BITS + HALL_BITS + DUTY_BITS + 1;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Register indexes
    localparam logic [2:0] REG_OVERSAMPLE = 3'd0;
    localparam logic [2:0] REG_FLOOR      = 3'd1;
    localparam logic [2:0] REG_CEILING    = 3'd2;
    localparam logic [2:0] REG_MIN_DUTY   = 3'd3;
    localparam logic [2:0] REG_DEAD_TIME  = 3'd4;

    // Register reset values
    localparam logic [OVS_BITS-1:0]  RST_OVERSAMPLE = OVS_BITS'(18);
    localparam logic [ADC_BITS-1:0]  RST_FLOOR      = ADC_BITS'(200);
    localparam logic [ADC_BITS-1:0]  RST_CEILING    = ADC_BITS'(2540);
    localparam logic [DUTY_BITS-1:0] RST_MIN_DUTY   = DUTY_BITS'(40);
    localparam logic [DUTY_BITS-1:0] RST_DEAD_TIME  = DUTY_BITS'(6);

    localparam logic [DUTY_BITS-1:0]  DUTY_MAX  = {DUTY_BITS{1'b1}};
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

    // Hall codes
    localparam logic [HALL_BITS-1:0] HALL_NONE = 3'd0;
    localparam logic [HALL_BITS-1:0] HALL_ALL  = 3'd7;

    // Low-side drive kinds
    localparam logic [1:0] LO_ZERO = 2'd0;   // low side value 0, compare 255
    localparam logic [1:0] LO_FULL = 2'd1;   // low side value 255, compare 0
    localparam logic [1:0] LO_COMP = 2'd2;   // complementary value with dead time

    typedef struct packed {
        logic [OVS_BITS-1:0]  oversample_count;
        logic [ADC_BITS-1:0]  throttle_floor;
        logic [ADC_BITS-1:0]  throttle_ceiling;
        logic [DUTY_BITS-1:0] min_run_duty;
        logic [DUTY_BITS-1:0] dead_time;
    } hsc_cfg_t;

    typedef struct packed {
        logic tally_en;   // add the hall bits to the tallies
        logic start;      // vote, clear tallies, capture throttle
        logic prep;       // form the scaled numerator
        logic step;       // one restoring division step
        logic load;       // write the output register
    } hsc_cmd_t;

    typedef struct packed {
        logic out_blocked;   // output register full and not taken
    } hsc_sts_t;

    typedef struct packed {
        logic [2:0] hi_on;   // bit p: phase p high side gets duty
        logic [1:0] lo_a;
        logic [1:0] lo_b;
        logic [1:0] lo_c;
    } hsc_sector_t;

    // Six-step sector table indexed by the voted hall code
    function automatic hsc_sector_t hsc_sector(input logic [HALL_BITS-1:0] code);
        hsc_sector_t s;
        s = '{hi_on: 3'b000, lo_a: LO_FULL, lo_b: LO_FULL, lo_c: LO_FULL};
        unique case (code)
            3'd1: s = '{hi_on: 3'b001, lo_a: LO_COMP, lo_b: LO_ZERO, lo_c: LO_FULL};
            3'd2: s = '{hi_on: 3'b100, lo_a: LO_ZERO, lo_b: LO_FULL, lo_c: LO_COMP};
            3'd3: s = '{hi_on: 3'b001, lo_a: LO_COMP, lo_b: LO_FULL, lo_c: LO_ZERO};
            3'd4: s = '{hi_on: 3'b010, lo_a: LO_FULL, lo_b: LO_COMP, lo_c: LO_ZERO};
            3'd5: s = '{hi_on: 3'b010, lo_a: LO_ZERO, lo_b: LO_COMP, lo_c: LO_FULL};
            3'd6: s = '{hi_on: 3'b100, lo_a: LO_FULL, lo_b: LO_ZERO, lo_c: LO_COMP};
            default: s = '{hi_on: 3'b000, lo_a: LO_FULL, lo_b: LO_FULL, lo_c: LO_FULL};
        endcase
        return s;
    endfunction

endpackage

### hdl/hsc_cfg.sv
// ============================================================================
// hsc_cfg
// APB register file holding the commutation settings.
// ============================================================================
module hsc_cfg
    import hsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output hsc_cfg_t           cfg
);

    hsc_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oversample_count <= RST_OVERSAMPLE;
            cfg_reg.throttle_floor   <= RST_FLOOR;
            cfg_reg.throttle_ceiling <= RST_CEILING;
            cfg_reg.min_run_duty     <= RST_MIN_DUTY;
            cfg_reg.dead_time        <= RST_DEAD_TIME;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OVERSAMPLE: cfg_reg.oversample_count <= pwdata[OVS_BITS-1:0];
                REG_FLOOR:      cfg_reg.throttle_floor   <= pwdata[ADC_BITS-1:0];
                REG_CEILING:    cfg_reg.throttle_ceiling <= pwdata[ADC_BITS-1:0];
                REG_MIN_DUTY:   cfg_reg.min_run_duty     <= pwdata[DUTY_BITS-1:0];
                REG_DEAD_TIME:  cfg_reg.dead_time        <= pwdata[DUTY_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_OVERSAMPLE: prdata = PDATA_W'(cfg_reg.oversample_count);
            REG_FLOOR:      prdata = PDATA_W'(cfg_reg.throttle_floor);
            REG_CEILING:    prdata = PDATA_W'(cfg_reg.throttle_ceiling);
            REG_MIN_DUTY:   prdata = PDATA_W'(cfg_reg.min_run_duty);
            REG_DEAD_TIME:  prdata = PDATA_W'(cfg_reg.dead_time);
            default:        prdata = '0;
        endcase
    end

endmodule

### hdl/hsc_ctrl.sv
// ============================================================================
// hsc_ctrl
// Sequencer: tally hall items, run the duty division, load the result.
// ============================================================================
`include "assert_macros.svh"

module hsc_ctrl
    import hsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    output logic     s_tready,
    input  hsc_sts_t sts,
    output hsc_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_cnt_reg;
    logic [STEP_W-1:0] step_cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cmd.tally_en = 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep      = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    `HSC_ASSERT(a_start_to_prep, cmd.start |=> (state_reg == ST_PREP),
        "commutate transfer did not enter the prepare step")
    `HSC_ASSERT(a_load_when_free, cmd.load |-> !sts.out_blocked,
        "result loaded over an untaken result")
    `HSC_ASSERT(a_div_count,
        (state_reg == ST_DIV && step_cnt_reg != STEP_LAST) |=>
            (state_reg == ST_DIV && step_cnt_reg == STEP_W'($past(step_cnt_reg) + 1'b1)),
        "division step count broke")

endmodule

### hdl/hsc_dp.sv
// ============================================================================
// hsc_dp
// Datapath: hall tallies, majority vote, duty divider and sector output.
// ============================================================================
`include "assert_macros.svh"

module hsc_dp
    import hsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsc_cfg_t             cfg,
    input  hsc_cmd_t             cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output hsc_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [TALLY_BITS-1:0] tally_reg [3];
    logic [HALL_BITS-1:0]  code_reg;
    logic                  zero_reg;
    logic                  full_reg;
    logic [ADC_BITS-1:0]   thr_reg;
    logic [ADC_BITS-1:0]   rem_reg;
    logic [DUTY_BITS-1:0]  numq_reg;
    logic [M_TDATA_W-1:0]  out_reg;
    logic                  m_tvalid_reg;

    logic [HALL_BITS-1:0]  hall_in;
    logic [ADC_BITS-1:0]   thr_in;
    logic [HALL_BITS-1:0]  vote;
    logic [ADC_BITS-1:0]   diff;
    logic [PROD_W-1:0]     prod;
    logic [ADC_BITS-1:0]   span;
    logic [ADC_BITS:0]     trial;
    logic [ADC_BITS:0]     trial_sub;
    logic                  fits;
    logic [DUTY_BITS-1:0]  duty;
    logic [DUTY_BITS:0]    duty_sum;
    logic [DUTY_BITS-1:0]  comp;
    logic                  run;
    hsc_sector_t           sector;
    logic [DUTY_BITS-1:0]  hi [3];
    logic [DUTY_BITS-1:0]  lo [3];
    logic [1:0]            lo_kind [3];
    logic [M_TDATA_W-1:0]  out_next;

    assign hall_in = s_tdata[HALL_BITS-1:0];
    assign thr_in  = s_tdata[HALL_BITS +: ADC_BITS];

    // Majority vote against half the oversample count
    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            vote[p] = VOTE_W'(tally_reg[p]) > VOTE_W'(cfg.oversample_count[OVS_BITS-1:1]);
        end
    end

    // Tally hall bits with saturation, clear on commutate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 3; p++)
            begin
                tally_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < 3; p++)
            begin
                if (cmd.start)
                begin
                    tally_reg[p] <= '0;
                end
                else if (cmd.tally_en && hall_in[p] && tally_reg[p] != TALLY_MAX)
                begin
                    tally_reg[p] <= tally_reg[p] + 1'b1;
                end
            end
        end
    end

    // Scaled numerator (t - floor) * 255 and divisor span
    assign diff = thr_reg - cfg.throttle_floor;
    assign prod = {diff, {DUTY_BITS{1'b0}}} - PROD_W'(diff);
    assign span = cfg.throttle_ceiling - cfg.throttle_floor;

    // One restoring division step
    assign trial     = {rem_reg, numq_reg[DUTY_BITS-1]};
    assign fits      = trial >= {1'b0, span};
    assign trial_sub = trial - {1'b0, span};

    // Capture the commutate item and run the divider
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            code_reg <= vote;
            thr_reg  <= thr_in;
            zero_reg <= (cfg.throttle_ceiling <= cfg.throttle_floor) ||
                        (thr_in <= cfg.throttle_floor);
            full_reg <= thr_in >= cfg.throttle_ceiling;
        end
        if (cmd.prep)
        begin
            rem_reg  <= prod[PROD_W-1:DUTY_BITS];
            numq_reg <= prod[DUTY_BITS-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg  <= fits ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
            numq_reg <= {numq_reg[DUTY_BITS-2:0], fits};
        end
    end

    // Saturated duty, dead-time complement and sector pattern
    always_comb
    begin
        if (zero_reg)
        begin
            duty = '0;
        end
        else if (full_reg)
        begin
            duty = DUTY_MAX;
        end
        else
        begin
            duty = numq_reg;
        end
        duty_sum = {1'b0, duty} + {1'b0, cfg.dead_time};
        comp     = (duty_sum >= {1'b0, DUTY_MAX}) ? '0 : DUTY_MAX - duty_sum[DUTY_BITS-1:0];
        run      = (duty >= cfg.min_run_duty) && (code_reg != HALL_NONE) &&
                   (code_reg != HALL_ALL);
        sector   = hsc_sector(code_reg);
        lo_kind[0] = sector.lo_a;
        lo_kind[1] = sector.lo_b;
        lo_kind[2] = sector.lo_c;
        for (int p = 0; p < 3; p++)
        begin
            hi[p] = (run && sector.hi_on[p]) ? duty : '0;
            if (!run)
            begin
                lo[p] = DUTY_MAX;
            end
            else
            begin
                case (lo_kind[p])
                    LO_ZERO: lo[p] = '0;
                    LO_COMP: lo[p] = comp;
                    default: lo[p] = DUTY_MAX;
                endcase
            end
        end
        out_next = '0;
        for (int p = 0; p < 3; p++)
        begin
            out_next[2*p*DUTY_BITS +: DUTY_BITS]         = hi[p];
            out_next[(2*p+1)*DUTY_BITS +: DUTY_BITS]     = DUTY_MAX - lo[p];
        end
        out_next[6*DUTY_BITS +: HALL_BITS]             = code_reg;
        out_next[6*DUTY_BITS+HALL_BITS +: DUTY_BITS]   = run ? duty : '0;
        out_next[7*DUTY_BITS+HALL_BITS]                = ~run;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg <= out_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = out_reg;
    assign sts.out_blocked = m_tvalid_reg & ~m_tready;

    `HSC_ASSERT(a_tally_cleared,
        cmd.start |=> (tally_reg[0] == '0 && tally_reg[1] == '0 && tally_reg[2] == '0),
        "tallies not cleared after commutate")
    `HSC_ASSERT(a_result_held,
        ($past(m_tvalid_reg) && !$past(m_tready)) |-> (m_tvalid_reg && $stable(out_reg)),
        "pending result changed before transfer")
    `HSC_ASSERT_NR(a_no_valid_in_reset, !rst_n |-> !m_tvalid,
        "result valid during reset")

endmodule

### hdl/six_step_hall_commutation_core.sv
// ============================================================================
// six_step_hall_commutation_core
// Six-step commutation from oversampled hall sensors and a throttle sample.
// ============================================================================
//  Channel  Dir  Handshake           Payload
//  s_axis   in   s_tvalid/s_tready   s_tdata: hall_sample, throttle_sample;
//                                    s_tuser: kind (0 tally, 1 commutate)
//  m_axis   out  m_tvalid/m_tready   m_tdata: six compares, hall_state,
//                                    duty_used, coasting
//  apb      in   psel/penable        five settings at byte addresses 0..16
//
//  Back-to-back hall items are taken every cycle while no commutate item is busy.
//  A commutate item runs through capture, numerator, 8 restoring division
//  steps (one quotient bit per cycle) and the output load.
//  The load waits while the previous result sits untaken in the output register.
//  Reset clears the tallies and restores the setting defaults; no sweep.
// ============================================================================
module six_step_hall_commutation_core
    import hsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // hall_sample [2:0], throttle_sample [14:3], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind [0]
    input  logic                 s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_high_cmp [7:0], a_low_cmp [15:8], b_high_cmp [23:16], b_low_cmp [31:24],
    // c_high_cmp [39:32], c_low_cmp [47:40], hall_state [50:48],
    // duty_used [58:51], coasting [59], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    hsc_cfg_t cfg;
    hsc_cmd_t cmd;
    hsc_sts_t sts;

    // Settings
    hsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    hsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    hsc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for six_step_hall_commutation_core. Hall and throttle
// transfers go in on the slave stream. A software copy of the tally, vote,
// duty scaling and sector logic predicts the commutation results that the
// stimulus rows do not give. Results from the master stream are checked field
// by field in arrival order. The run starts with a short stimulus table and
// then walks through several register settings with random sequences, random
// stalls on both sides, one long output hold-off and two full drain pauses.
// ============================================================================
module tb_top;
    import hsc_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ADC_TOP          = (1 << ADC_BITS) - 1;
    localparam int NUM_PHASES       = 8;

    // Low-side compare levels: low side fully on / fully off
    localparam logic [DUTY_BITS-1:0] CMP_LOW_ON  = DUTY_MAX;
    localparam logic [DUTY_BITS-1:0] CMP_LOW_OFF = '0;

    typedef enum logic {KIND_HALL, KIND_COMMUTATE} kind_e;

    // Hall codes, named by the phases whose sensor is high
    typedef enum logic [HALL_BITS-1:0] {
        HC_NONE, HC_A, HC_B, HC_AB, HC_C, HC_AC, HC_BC, HC_ALL
    } hall_code_e;

    // One commutation result, laid out as the low bits of m_tdata
    typedef struct packed {
        logic                 coasting;
        logic [DUTY_BITS-1:0] duty_used;
        logic [HALL_BITS-1:0] hall_state;
        logic [DUTY_BITS-1:0] c_low_cmp;
        logic [DUTY_BITS-1:0] c_high_cmp;
        logic [DUTY_BITS-1:0] b_low_cmp;
        logic [DUTY_BITS-1:0] b_high_cmp;
        logic [DUTY_BITS-1:0] a_low_cmp;
        logic [DUTY_BITS-1:0] a_high_cmp;
    } gate_cmd_t;

    typedef struct {
        kind_e                kind;
        logic [HALL_BITS-1:0] hall;
        logic [ADC_BITS-1:0]  throttle;
        bit                   typed;
        gate_cmd_t            want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    // hall_sample [2:0], throttle_sample [14:3], zero fill above
    logic [S_TDATA_W-1:0] s_tdata;
    // kind [0]
    logic                 s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    // a_high_cmp [7:0], a_low_cmp [15:8], b_high_cmp [23:16], b_low_cmp [31:24],
    // c_high_cmp [39:32], c_low_cmp [47:40], hall_state [50:48],
    // duty_used [58:51], coasting [59], zero fill above
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shadow of the block: settings and per-phase hall tallies
    hsc_cfg_t              cfg_shadow;
    logic [TALLY_BITS-1:0] hall_tally [3];

    gate_cmd_t pending_gates [$];
    stim_row_t directed_rows [$];
    int        mismatch_count;
    bit        idle_on;
    bit        long_hold_req;

    six_step_hall_commutation_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Tally hall bits, or vote, scale the throttle and pick the sector
    function automatic bit predict_gates(input kind_e kind,
                                         input logic [HALL_BITS-1:0] hall,
                                         input logic [ADC_BITS-1:0] throttle,
                                         output gate_cmd_t res);
        logic [HALL_BITS-1:0] code;
        logic [OVS_BITS-1:0]  half;
        int                   duty;
        int                   comp;
        res  = '0;
        code = '0;
        if (kind == KIND_HALL)
        begin
            for (int p = 0; p < 3; p++)
                if (hall[p] && hall_tally[p] != TALLY_MAX)
                    hall_tally[p] = hall_tally[p] + 1'b1;
            return 1'b0;
        end

        // Majority vote per phase, then clear the tallies
        half = cfg_shadow.oversample_count >> 1;
        for (int p = 0; p < 3; p++)
        begin
            code[p]       = (hall_tally[p] > half);
            hall_tally[p] = '0;
        end

        // Linear scale of the floor..ceiling band, clamped at both ends
        if (cfg_shadow.throttle_ceiling <= cfg_shadow.throttle_floor
            || throttle <= cfg_shadow.throttle_floor)
            duty = 0;
        else
        begin
            duty = ((int'(throttle) - int'(cfg_shadow.throttle_floor)) * 255)
                   / (int'(cfg_shadow.throttle_ceiling) - int'(cfg_shadow.throttle_floor));
            if (duty > 255)
                duty = 255;
        end
        if (duty + int'(cfg_shadow.dead_time) >= 255)
            comp = 0;
        else
            comp = 255 - duty - int'(cfg_shadow.dead_time);

        res.hall_state = code;
        res.coasting   = 1'b1;
        if (duty >= int'(cfg_shadow.min_run_duty) && code != HC_NONE && code != HC_ALL)
        begin
            res.coasting  = 1'b0;
            res.duty_used = duty[7:0];
            case (hall_code_e'(code))
                HC_A:
                begin
                    res.a_high_cmp = duty[7:0];
                    res.a_low_cmp  = 8'(255 - comp);
                    res.b_low_cmp  = CMP_LOW_ON;
                    res.c_low_cmp  = CMP_LOW_OFF;
                end
                HC_B:
                begin
                    res.c_high_cmp = duty[7:0];
                    res.a_low_cmp  = CMP_LOW_ON;
                    res.b_low_cmp  = CMP_LOW_OFF;
                    res.c_low_cmp  = 8'(255 - comp);
                end
                HC_AB:
                begin
                    res.a_high_cmp = duty[7:0];
                    res.a_low_cmp  = 8'(255 - comp);
                    res.b_low_cmp  = CMP_LOW_OFF;
                    res.c_low_cmp  = CMP_LOW_ON;
                end
                HC_C:
                begin
                    res.b_high_cmp = duty[7:0];
                    res.a_low_cmp  = CMP_LOW_OFF;
                    res.b_low_cmp  = 8'(255 - comp);
                    res.c_low_cmp  = CMP_LOW_ON;
                end
                HC_AC:
                begin
                    res.b_high_cmp = duty[7:0];
                    res.a_low_cmp  = CMP_LOW_ON;
                    res.b_low_cmp  = 8'(255 - comp);
                    res.c_low_cmp  = CMP_LOW_OFF;
                end
                HC_BC:
                begin
                    res.c_high_cmp = duty[7:0];
                    res.a_low_cmp  = CMP_LOW_OFF;
                    res.b_low_cmp  = CMP_LOW_ON;
                    res.c_low_cmp  = 8'(255 - comp);
                end
                default:
                begin
                end
            endcase
        end
        return 1'b1;
    endfunction

    function automatic gate_cmd_t mk_gates(input int a_hi, input int a_lo,
                                           input int b_hi, input int b_lo,
                                           input int c_hi, input int c_lo,
                                           input logic [2:0] hs, input int duty,
                                           input int coast);
        gate_cmd_t g;
        g.a_high_cmp = DUTY_BITS'(a_hi);
        g.a_low_cmp  = DUTY_BITS'(a_lo);
        g.b_high_cmp = DUTY_BITS'(b_hi);
        g.b_low_cmp  = DUTY_BITS'(b_lo);
        g.c_high_cmp = DUTY_BITS'(c_hi);
        g.c_low_cmp  = DUTY_BITS'(c_lo);
        g.hall_state = hs;
        g.duty_used  = DUTY_BITS'(duty);
        g.coasting   = 1'(coast);
        return g;
    endfunction

    // Throttle values: anywhere, inside the band, or close to either edge
    function automatic logic [ADC_BITS-1:0] pick_throttle();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, ADC_TOP);
            1: v = $urandom_range(cfg_shadow.throttle_floor, cfg_shadow.throttle_ceiling);
            2: v = int'(cfg_shadow.throttle_floor) + $urandom_range(0, 4) - 2;
            default: v = int'(cfg_shadow.throttle_ceiling) + $urandom_range(0, 4) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > ADC_TOP)
            v = ADC_TOP;
        return v[ADC_BITS-1:0];
    endfunction

    task automatic add_row(input kind_e kind, input logic [HALL_BITS-1:0] hall,
                           input int throttle, input bit typed, input gate_cmd_t want);
        stim_row_t row;
        row.kind     = kind;
        row.hall     = hall;
        row.throttle = throttle[ADC_BITS-1:0];
        row.typed    = typed;
        row.want     = want;
        directed_rows.push_back(row);
    endtask

    // Offer one transfer after a random gap, then record what it should cause
    task automatic send_item(input kind_e kind, input logic [HALL_BITS-1:0] hall,
                             input logic [ADC_BITS-1:0] throttle,
                             input bit typed, input gate_cmd_t want);
        int        gap;
        gate_cmd_t predicted;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({throttle, hall});
        do @(posedge clk); while (!s_tready);
        if (predict_gates(kind, hall, throttle, predicted))
            pending_gates.push_back(typed ? want : predicted);
    endtask

    // Stop offering, drain all pending results, let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_gates.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup phase, access phase, then the bus goes idle
    task automatic apb_access(input bit wr, input logic [2:0] idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a setting, mirror it in the shadow and read it back
    task automatic program_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] stored;
        case (idx)
            REG_OVERSAMPLE:
            begin
                cfg_shadow.oversample_count = val[OVS_BITS-1:0];
                stored = PDATA_W'(cfg_shadow.oversample_count);
            end
            REG_FLOOR:
            begin
                cfg_shadow.throttle_floor = val[ADC_BITS-1:0];
                stored = PDATA_W'(cfg_shadow.throttle_floor);
            end
            REG_CEILING:
            begin
                cfg_shadow.throttle_ceiling = val[ADC_BITS-1:0];
                stored = PDATA_W'(cfg_shadow.throttle_ceiling);
            end
            REG_MIN_DUTY:
            begin
                cfg_shadow.min_run_duty = val[DUTY_BITS-1:0];
                stored = PDATA_W'(cfg_shadow.min_run_duty);
            end
            REG_DEAD_TIME:
            begin
                cfg_shadow.dead_time = val[DUTY_BITS-1:0];
                stored = PDATA_W'(cfg_shadow.dead_time);
            end
            default: stored = '0;
        endcase
        apb_access(1'b1, idx, val, readback);
        apb_access(1'b0, idx, '0, readback);
        if (readback !== stored)
        begin
            $display("%0t: register %0d readback expected %0h, actual %0h",
                     $time, idx, stored, readback);
            mismatch_count++;
        end
    endtask

    // Mostly hall runs aimed at one code followed by a commutate, some lone noise
    task automatic run_random(input int item_goal, input int commutate_goal,
                              input bit force_long, input bit pause_midway);
        int                   items;
        int                   commutes;
        int                   run_len;
        int                   pick;
        bit                   want_long;
        bit                   paused;
        kind_e                kind;
        logic [HALL_BITS-1:0] target;
        items     = 0;
        commutes  = 0;
        want_long = force_long;
        paused    = 1'b0;
        while (items < item_goal || commutes < commutate_goal)
        begin
            if (pause_midway && !paused && items >= item_goal / 2)
            begin
                settle();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 3 && !want_long)
            begin
                kind = kind_e'($urandom_range(0, 1));
                send_item(kind, 3'($urandom), pick_throttle(), 1'b0, '0);
                items++;
                if (kind == KIND_COMMUTATE)
                    commutes++;
            end
            else
            begin
                // long runs push the tallies into saturation
                if (pick == 3 || want_long)
                    run_len = $urandom_range(64, 80);
                else
                    run_len = $urandom_range(0, cfg_shadow.oversample_count + 2);
                want_long = 1'b0;
                target    = 3'($urandom);
                repeat (run_len)
                    send_item(KIND_HALL,
                              ($urandom_range(0, 7) == 0) ? 3'($urandom) : target,
                              ADC_BITS'($urandom), 1'b0, '0);
                send_item(KIND_COMMUTATE, 3'($urandom), pick_throttle(), 1'b0, '0);
                items    += run_len + 1;
                commutes++;
            end
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls, one long hold-off on request, check each transfer
    initial
    begin
        int        stall;
        gate_cmd_t want;
        gate_cmd_t got;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (long_hold_req)
            begin
                stall         = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = gate_cmd_t'(m_tdata[M_USED_W-1:0]);
            if (pending_gates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_gates.pop_front();
                report_field("a_high_cmp", want.a_high_cmp, got.a_high_cmp);
                report_field("a_low_cmp",  want.a_low_cmp,  got.a_low_cmp);
                report_field("b_high_cmp", want.b_high_cmp, got.b_high_cmp);
                report_field("b_low_cmp",  want.b_low_cmp,  got.b_low_cmp);
                report_field("c_high_cmp", want.c_high_cmp, got.c_high_cmp);
                report_field("c_low_cmp",  want.c_low_cmp,  got.c_low_cmp);
                report_field("hall_state", 8'(want.hall_state), 8'(got.hall_state));
                report_field("duty_used",  want.duty_used,  got.duty_used);
                report_field("coasting",   8'(want.coasting), 8'(got.coasting));
            end
        end
    end

    // Watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        hsc_cfg_t phase_cfg;
        int       ceil_lo;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        mismatch_count = 0;
        long_hold_req  = 1'b0;
        idle_on        = 1'b1;
        cfg_shadow = '{RST_OVERSAMPLE, RST_FLOOR, RST_CEILING, RST_MIN_DUTY, RST_DEAD_TIME};
        for (int p = 0; p < 3; p++)
            hall_tally[p] = '0;

        // Commutate straight out of reset: empty tallies coast; hall bits ignored
        add_row(KIND_COMMUTATE, HC_ALL, 0, 1'b1, mk_gates(0, 0, 0, 0, 0, 0, HC_NONE, 0, 1));
        // From here one hall sample decides the vote
        add_row(KIND_HALL, HC_A, ADC_TOP, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, ADC_TOP, 1'b1,
                mk_gates(255, 255, 0, 255, 0, 0, HC_A, 255, 0));
        add_row(KIND_HALL, HC_B, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 2540, 1'b0, '0);
        add_row(KIND_HALL, HC_AB, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 201, 1'b0, '0);
        add_row(KIND_HALL, HC_C, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 1370, 1'b0, '0);
        add_row(KIND_HALL, HC_AC, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 1000, 1'b0, '0);
        add_row(KIND_HALL, HC_BC, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 3000, 1'b0, '0);
        // Invalid hall codes coast but still report the code
        add_row(KIND_HALL, HC_ALL, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, ADC_TOP, 1'b1,
                mk_gates(0, 0, 0, 0, 0, 0, HC_ALL, 0, 1));
        add_row(KIND_HALL, HC_NONE, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, ADC_TOP, 1'b1,
                mk_gates(0, 0, 0, 0, 0, 0, HC_NONE, 0, 1));
        // Throttle at and below the floor gives duty zero
        add_row(KIND_HALL, HC_A, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 200, 1'b1, mk_gates(0, 0, 0, 0, 0, 0, HC_A, 0, 1));
        add_row(KIND_HALL, HC_AB, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 199, 1'b1, mk_gates(0, 0, 0, 0, 0, 0, HC_AB, 0, 1));
        // Duty just below, at and above the minimum run duty
        add_row(KIND_HALL, HC_C, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 558, 1'b0, '0);
        add_row(KIND_HALL, HC_C, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 568, 1'b0, '0);
        add_row(KIND_HALL, HC_BC, 0, 1'b0, '0);
        add_row(KIND_COMMUTATE, HC_NONE, 672, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the stimulus table; drop the vote threshold after the first row
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (i == 1)
            begin
                settle();
                program_reg(REG_OVERSAMPLE, 1);
            end
            send_item(directed_rows[i].kind, directed_rows[i].hall,
                      directed_rows[i].throttle, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // Random phases over defaults, extremes and random settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_cfg = '{RST_OVERSAMPLE, RST_FLOOR, RST_CEILING,
                                 RST_MIN_DUTY, RST_DEAD_TIME};
                1: phase_cfg = '{6'd0, 12'd0, 12'd4095, 8'd0, 8'd0};
                2: phase_cfg = '{6'd63, 12'd0, 12'd4095, 8'd255, 8'd255};
                3: phase_cfg = '{6'd5, 12'd4095, 12'd0, 8'd0, 8'd128};
                4: phase_cfg = '{6'd9, 12'd1000, 12'd1000, 8'd0, 8'd255};
                default:
                begin
                    phase_cfg.oversample_count = OVS_BITS'($urandom_range(0, 24));
                    phase_cfg.throttle_floor   = ADC_BITS'($urandom_range(0, 3000));
                    ceil_lo                    = int'(phase_cfg.throttle_floor) + 1;
                    phase_cfg.throttle_ceiling = ADC_BITS'($urandom_range(ceil_lo, ADC_TOP));
                    phase_cfg.min_run_duty     = DUTY_BITS'($urandom_range(0, 100));
                    phase_cfg.dead_time        = DUTY_BITS'($urandom_range(0, 255));
                end
            endcase
            settle();
            program_reg(REG_OVERSAMPLE, PDATA_W'(phase_cfg.oversample_count));
            program_reg(REG_FLOOR,      PDATA_W'(phase_cfg.throttle_floor));
            program_reg(REG_CEILING,    PDATA_W'(phase_cfg.throttle_ceiling));
            program_reg(REG_MIN_DUTY,   PDATA_W'(phase_cfg.min_run_duty));
            program_reg(REG_DEAD_TIME,  PDATA_W'(phase_cfg.dead_time));
            idle_on       = (p != 1 && p != 4);
            long_hold_req = (p == 1);
            run_random(30, 3, (p == 0 || p == 5), (p == 2 || p == 6));
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/hsc_pkg.sv
hdl/hsc_cfg.sv
hdl/hsc_ctrl.sv
hdl/hsc_dp.sv
hdl/six_step_hall_commutation_core.sv
dv/tb_top.sv
